>>> design/assert_macros.svh
// Assertion macros shared by the route table lookup RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property violated");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

>>> design/pat_pkg.sv
// Package for the prefix/AS table lookup unit: types, codes and the microcode ROM.
// Used by pat_sequencer, pat_datapath, prefix_as_table_lookup_unit and tb_top; no dependencies.
package pat_pkg;

    localparam int DEPTH_DEFAULT = 4096;
    localparam int STEP_W        = 5;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [5:0] LEN_MAX  = 6'd32;
    localparam logic [5:0] LEN_MISS = 6'd32;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        logic [31:0] net;
        logic [15:0] asn;
        logic [5:0]  len;
    } entry_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_CLEAR,
        OP_RSP_NONE,
        OP_RSP_INVALID,
        OP_RSP_FULL,
        OP_INS_INIT,
        OP_READ_PREV,
        OP_SHIFT,
        OP_PLACE,
        OP_LK_INIT,
        OP_READ_MID,
        OP_LO_UP,
        OP_HI_DOWN,
        OP_READ_LO,
        OP_RSP_MISS,
        OP_RSP_HIT
    } dp_op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_ACT_CLEAR,
        C_ACT_INSERT,
        C_ACT_LOOKUP,
        C_INVALID,
        C_FULL,
        C_POS_ZERO,
        C_NOT_AFTER,
        C_SPAN_LE1,
        C_MID_OUT,
        C_MATCH,
        C_GREATER,
        C_LO_OUT
    } cond_t;

    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        step_t  target;
    } ucode_t;

    typedef struct packed {
        logic act_clear;
        logic act_insert;
        logic act_lookup;
        logic invalid;
        logic full;
        logic pos_zero;
        logic after;
        logic span_le1;
        logic mid_out;
        logic lo_out;
        logic match;
        logic greater;
    } dp_flags_t;

    localparam step_t S_IDLE      = 5'd0;
    localparam step_t S_DISP0     = 5'd1;
    localparam step_t S_DISP1     = 5'd2;
    localparam step_t S_DISP2     = 5'd3;
    localparam step_t S_NONE      = 5'd4;
    localparam step_t S_CLEAR     = 5'd5;
    localparam step_t S_INS       = 5'd6;
    localparam step_t S_INS_CHK   = 5'd7;
    localparam step_t S_INS_INIT  = 5'd8;
    localparam step_t S_INS_LOOP  = 5'd9;
    localparam step_t S_INS_READ  = 5'd10;
    localparam step_t S_INS_TEST  = 5'd11;
    localparam step_t S_INS_SHIFT = 5'd12;
    localparam step_t S_PLACE     = 5'd13;
    localparam step_t S_INS_BAD   = 5'd14;
    localparam step_t S_INS_FULL  = 5'd15;
    localparam step_t S_LK        = 5'd16;
    localparam step_t S_LK_LOOP   = 5'd17;
    localparam step_t S_LK_READ   = 5'd18;
    localparam step_t S_LK_TEST   = 5'd19;
    localparam step_t S_LK_DIR    = 5'd20;
    localparam step_t S_LK_RIGHT  = 5'd21;
    localparam step_t S_LK_LEFT   = 5'd22;
    localparam step_t S_LK_LAST   = 5'd23;
    localparam step_t S_LK_LTEST  = 5'd24;
    localparam step_t S_MISS      = 5'd25;
    localparam step_t S_HIT       = 5'd26;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        case (step)
            S_IDLE:      w = '{OP_LATCH,       C_NO_START,   S_IDLE};
            S_DISP0:     w = '{OP_NOP,         C_ACT_CLEAR,  S_CLEAR};
            S_DISP1:     w = '{OP_NOP,         C_ACT_INSERT, S_INS};
            S_DISP2:     w = '{OP_NOP,         C_ACT_LOOKUP, S_LK};
            S_NONE:      w = '{OP_RSP_NONE,    C_ALWAYS,     S_IDLE};
            S_CLEAR:     w = '{OP_CLEAR,       C_ALWAYS,     S_IDLE};
            S_INS:       w = '{OP_NOP,         C_INVALID,    S_INS_BAD};
            S_INS_CHK:   w = '{OP_NOP,         C_FULL,       S_INS_FULL};
            S_INS_INIT:  w = '{OP_INS_INIT,    C_NEVER,      S_IDLE};
            S_INS_LOOP:  w = '{OP_NOP,         C_POS_ZERO,   S_PLACE};
            S_INS_READ:  w = '{OP_READ_PREV,   C_NEVER,      S_IDLE};
            S_INS_TEST:  w = '{OP_NOP,         C_NOT_AFTER,  S_PLACE};
            S_INS_SHIFT: w = '{OP_SHIFT,       C_ALWAYS,     S_INS_LOOP};
            S_PLACE:     w = '{OP_PLACE,       C_ALWAYS,     S_IDLE};
            S_INS_BAD:   w = '{OP_RSP_INVALID, C_ALWAYS,     S_IDLE};
            S_INS_FULL:  w = '{OP_RSP_FULL,    C_ALWAYS,     S_IDLE};
            S_LK:        w = '{OP_LK_INIT,     C_NEVER,      S_IDLE};
            S_LK_LOOP:   w = '{OP_NOP,         C_SPAN_LE1,   S_LK_LAST};
            S_LK_READ:   w = '{OP_READ_MID,    C_MID_OUT,    S_MISS};
            S_LK_TEST:   w = '{OP_NOP,         C_MATCH,      S_HIT};
            S_LK_DIR:    w = '{OP_NOP,         C_GREATER,    S_LK_LEFT};
            S_LK_RIGHT:  w = '{OP_LO_UP,       C_ALWAYS,     S_LK_LOOP};
            S_LK_LEFT:   w = '{OP_HI_DOWN,     C_ALWAYS,     S_LK_LOOP};
            S_LK_LAST:   w = '{OP_READ_LO,     C_LO_OUT,     S_MISS};
            S_LK_LTEST:  w = '{OP_NOP,         C_MATCH,      S_HIT};
            S_MISS:      w = '{OP_RSP_MISS,    C_ALWAYS,     S_IDLE};
            S_HIT:       w = '{OP_RSP_HIT,     C_ALWAYS,     S_IDLE};
            default:     w = '{OP_NOP,         C_ALWAYS,     S_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [31:0] len_mask(input logic [5:0] len);
        logic [31:0] m;
        if (len >= LEN_MAX) begin
            m = 32'hFFFF_FFFF;
        end else begin
            m = ~(32'hFFFF_FFFF >> len);
        end
        return m;
    endfunction

endpackage

>>> design/pat_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on pat_pkg for the ROM, condition codes and flag struct.
module pat_sequencer
    import pat_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  dp_flags_t flags,
    output dp_op_t    op,
    output logic      busy
);

    step_t  upc_reg;
    step_t  upc_next;
    ucode_t word;
    logic   take;

    assign word = ucode_rom(upc_reg);
    assign busy = (upc_reg != S_IDLE);

    always_comb
    begin
        case (word.cond)
            C_NEVER:      take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NO_START:   take = !start;
            C_ACT_CLEAR:  take = flags.act_clear;
            C_ACT_INSERT: take = flags.act_insert;
            C_ACT_LOOKUP: take = flags.act_lookup;
            C_INVALID:    take = flags.invalid;
            C_FULL:       take = flags.full;
            C_POS_ZERO:   take = flags.pos_zero;
            C_NOT_AFTER:  take = !flags.after;
            C_SPAN_LE1:   take = flags.span_le1;
            C_MID_OUT:    take = flags.mid_out;
            C_MATCH:      take = flags.match;
            C_GREATER:    take = flags.greater;
            C_LO_OUT:     take = flags.lo_out;
            default:      take = 1'b0;
        endcase
        upc_next = take ? word.target : upc_reg + step_t'(1);
    end

    // The idle word only latches a command when one is actually transferred.
    assign op = (upc_reg == S_IDLE && !start) ? OP_NOP : word.op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            upc_reg <= S_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

>>> design/pat_datapath.sv
// Datapath: command registers, search bounds, route table memory and result registers.
// Depends on pat_pkg and assert_macros.svh; driven by pat_sequencer.
`include "assert_macros.svh"
module pat_datapath
    import pat_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_op_t      op,
    input  logic [1:0]  action,
    input  logic [31:0] address,
    input  logic [5:0]  prefix_len,
    input  logic [15:0] as_number,
    output dp_flags_t   flags,
    output logic        done,
    output logic        hit,
    output logic [15:0] found_as,
    output logic [5:0]  found_len,
    output logic [1:0]  status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    entry_t      mem [TABLE_DEPTH];
    entry_t      q_reg;

    logic [1:0]  action_reg;
    logic [31:0] addr_reg;
    logic [5:0]  len_reg;
    logic [15:0] asn_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] pos_reg, pos_next;

    logic        done_reg, done_next;
    logic        hit_reg, hit_next;
    logic [15:0] fas_reg, fas_next;
    logic [5:0]  flen_reg, flen_next;
    logic [1:0]  status_reg, status_next;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic [CW-1:0] pos_dec;
    logic [31:0]   masked;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CW:1];
    assign pos_dec = pos_reg - CW'(1);
    assign masked  = addr_reg & len_mask(q_reg.len);

    always_comb
    begin
        flags.act_clear  = (action_reg == ACT_CLEAR);
        flags.act_insert = (action_reg == ACT_INSERT);
        flags.act_lookup = (action_reg == ACT_LOOKUP);
        flags.invalid    = (addr_reg == 32'd0) || (len_reg == 6'd0) || (len_reg > LEN_MAX);
        flags.full       = (count_reg == CW'(TABLE_DEPTH));
        flags.pos_zero   = (pos_reg == '0);
        flags.after      = (q_reg.net != addr_reg) ? (q_reg.net > addr_reg)
                                                   : (q_reg.len > len_reg);
        flags.span_le1   = ({1'b0, hi_reg} <= ({1'b0, lo_reg} + (CW+1)'(1)));
        flags.mid_out    = (mid >= count_reg);
        flags.lo_out     = (lo_reg >= count_reg);
        flags.match      = (q_reg.net == masked);
        flags.greater    = (q_reg.net > masked);
    end

    always_comb
    begin
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        pos_next    = pos_reg;
        done_next   = 1'b0;
        hit_next    = hit_reg;
        fas_next    = fas_reg;
        flen_next   = flen_reg;
        status_next = status_reg;
        rd_en       = 1'b0;
        rd_addr     = mid[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = pos_reg[AW-1:0];
        wr_data     = q_reg;
        case (op)
            OP_CLEAR, OP_RSP_NONE, OP_RSP_INVALID, OP_RSP_FULL, OP_PLACE:
            begin
                done_next   = 1'b1;
                hit_next    = 1'b0;
                fas_next    = 16'd0;
                flen_next   = 6'd0;
                status_next = ST_OK;
                if (op == OP_CLEAR) begin
                    count_next = '0;
                end
                if (op == OP_RSP_INVALID) begin
                    status_next = ST_INVALID;
                end
                if (op == OP_RSP_FULL) begin
                    status_next = ST_FULL;
                end
                if (op == OP_PLACE) begin
                    wr_en      = 1'b1;
                    wr_data    = '{addr_reg, asn_reg, len_reg};
                    count_next = count_reg + CW'(1);
                end
            end
            OP_INS_INIT:
            begin
                pos_next = count_reg;
            end
            OP_READ_PREV:
            begin
                rd_en   = 1'b1;
                rd_addr = pos_dec[AW-1:0];
            end
            OP_SHIFT:
            begin
                wr_en    = 1'b1;
                pos_next = pos_dec;
            end
            OP_LK_INIT:
            begin
                lo_next = '0;
                hi_next = count_reg;
            end
            OP_READ_MID:
            begin
                rd_en = 1'b1;
            end
            OP_LO_UP:
            begin
                lo_next = mid + CW'(1);
            end
            OP_HI_DOWN:
            begin
                hi_next = mid;
            end
            OP_READ_LO:
            begin
                rd_en   = 1'b1;
                rd_addr = lo_reg[AW-1:0];
            end
            OP_RSP_MISS:
            begin
                done_next   = 1'b1;
                hit_next    = 1'b0;
                fas_next    = 16'd0;
                flen_next   = LEN_MISS;
                status_next = ST_OK;
            end
            OP_RSP_HIT:
            begin
                done_next   = 1'b1;
                hit_next    = 1'b1;
                fas_next    = q_reg.asn;
                flen_next   = q_reg.len;
                status_next = ST_OK;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_reg <= mem[rd_addr];
        end
        if (op == OP_LATCH) begin
            action_reg <= action;
            addr_reg   <= address;
            len_reg    <= prefix_len;
            asn_reg    <= as_number;
        end
        hit_reg    <= hit_next;
        fas_reg    <= fas_next;
        flen_reg   <= flen_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            done_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            done_reg  <= done_next;
        end
    end

    assign done      = done_reg;
    assign hit       = hit_reg;
    assign found_as  = fas_reg;
    assign found_len = flen_reg;
    assign status    = status_reg;

    // The entry count never passes the table depth, and an insert grows it by one.
    `ASSERT_PROP(a_count_bound, clk, rst_n, count_reg <= CW'(TABLE_DEPTH))
    `ASSERT_PROP(a_place_grows, clk, rst_n, op == OP_PLACE |=> count_reg == $past(count_reg) + CW'(1))
    // The search window stays well formed through every halving step.
    `ASSERT_NEVER(a_window_order, clk, rst_n, lo_reg > hi_reg)

endmodule

>>> design/prefix_as_table_lookup_unit.sv
// The microcode advances one word per cycle and table reads are registered.
// Reset zeroes the entry count, search bounds, done and the microcode step counter.
// One command at a time; busy drops in the cycle that done pulses, and the result shows for
// exactly one cycle with done and cannot be stalled.
// Depends on pat_pkg, pat_sequencer and pat_datapath.
module prefix_as_table_lookup_unit
    import pat_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] address,
    input  logic [5:0]  prefix_len,
    input  logic [15:0] as_number,
    output logic        done,
    output logic        hit,
    output logic [15:0] found_as,
    output logic [5:0]  found_len,
    output logic [1:0]  status
);

    dp_op_t    op;
    dp_flags_t flags;

    pat_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .op    (op),
        .busy  (busy)
    );

    pat_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .action     (action),
        .address    (address),
        .prefix_len (prefix_len),
        .as_number  (as_number),
        .flags      (flags),
        .done       (done),
        .hit        (hit),
        .found_as   (found_as),
        .found_len  (found_len),
        .status     (status)
    );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for prefix_as_table_lookup_unit: directed, random and sorted-fill
// command transfers checked against an in-bench prefix table predictor.
// Depends on pat_pkg and the prefix_as_table_lookup_unit RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pat_pkg::*;

    localparam int         RT_DEPTH    = DEPTH_DEFAULT;
    localparam int         CYCLE_LIMIT = 2_000_000;
    localparam int         RAND_ITEMS  = 320;
    localparam int         FILL_ITEMS  = 48;
    localparam int         SHADOW_MAX  = 160;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] address;
        logic [5:0]  plen;
        logic [15:0] asn;
    } route_cmd_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] found_as;
        logic [5:0]  found_len;
        logic [1:0]  status;
    } route_rsp_t;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic [1:0]  action     = ACT_CLEAR;
    logic [31:0] address    = '0;
    logic [5:0]  prefix_len = '0;
    logic [15:0] as_number  = '0;
    logic        busy;
    logic        done;
    logic        hit;
    logic [15:0] found_as;
    logic [5:0]  found_len;
    logic [1:0]  status;

    route_cmd_t  cmd_fifo[$];
    route_rsp_t  pending_rsp[$];
    route_cmd_t  cur_cmd;
    logic [31:0] shadow_net[$];
    logic [5:0]  shadow_len[$];

    entry_t      rt_table[RT_DEPTH];
    int unsigned rt_count  = 0;
    int          err_count = 0;
    int          sent_count = 0;
    int          issued_count = 0;
    int          gap_left  = 0;
    int          cycle_count = 0;

    prefix_as_table_lookup_unit #(.TABLE_DEPTH(RT_DEPTH)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .address    (address),
        .prefix_len (prefix_len),
        .as_number  (as_number),
        .done       (done),
        .hit        (hit),
        .found_as   (found_as),
        .found_len  (found_len),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        if (len == 6'd0)
        begin
            return 32'h0;
        end
        if (len >= LEN_MAX)
        begin
            return 32'hFFFF_FFFF;
        end
        return 32'hFFFF_FFFF << (6'd32 - len);
    endfunction

    function automatic logic [1:0] insert_route(input logic [31:0] net, input logic [5:0] len,
                                                input logic [15:0] asn);
        int unsigned pos;
        int unsigned i;
        if (net == 32'h0 || len == 6'd0 || len > LEN_MAX)
        begin
            return ST_INVALID;
        end
        if (rt_count >= RT_DEPTH)
        begin
            return ST_FULL;
        end
        pos = rt_count;
        while (pos > 0 && (rt_table[pos-1].net > net ||
               (rt_table[pos-1].net == net && rt_table[pos-1].len > len)))
        begin
            pos--;
        end
        for (i = rt_count; i > pos; i--)
        begin
            rt_table[i] = rt_table[i-1];
        end
        rt_table[pos] = '{net: net, asn: asn, len: len};
        rt_count++;
        return ST_OK;
    endfunction

    // Halving search exactly as the block does it; it may miss a covering prefix.
    function automatic int find_route(input logic [31:0] addr);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        logic [31:0] masked;
        lo = 0;
        hi = rt_count;
        while (hi > lo + 1)
        begin
            mid = (lo + hi) / 2;
            masked = addr & prefix_mask(rt_table[mid].len);
            if (rt_table[mid].net == masked)
            begin
                return int'(mid);
            end
            if (rt_table[mid].net > masked)
            begin
                hi = mid;
            end
            else
            begin
                lo = mid + 1;
            end
        end
        if (lo >= rt_count)
        begin
            return -1;
        end
        if (rt_table[lo].net == (addr & prefix_mask(rt_table[lo].len)))
        begin
            return int'(lo);
        end
        return -1;
    endfunction

    function automatic route_rsp_t predict_response(input route_cmd_t c);
        route_rsp_t r;
        int idx;
        r = '0;
        case (c.action)
            ACT_CLEAR:
            begin
                rt_count = 0;
            end
            ACT_INSERT:
            begin
                r.status = insert_route(c.address, c.plen, c.asn);
            end
            ACT_LOOKUP:
            begin
                idx = find_route(c.address);
                if (idx >= 0)
                begin
                    r.hit = 1'b1;
                    r.found_as = rt_table[idx].asn;
                    r.found_len = rt_table[idx].len;
                end
                else
                begin
                    r.found_len = LEN_MISS;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic add_cmd(input logic [1:0] act, input logic [31:0] addr,
                           input logic [5:0] len, input logic [15:0] asn);
        cmd_fifo.push_back('{action: act, address: addr, plen: len, asn: asn});
        issued_count++;
        if (act == ACT_CLEAR)
        begin
            shadow_net.delete();
            shadow_len.delete();
        end
        else if (act == ACT_INSERT && addr != 32'h0 && len != 6'd0 && len <= LEN_MAX)
        begin
            shadow_net.push_back(addr);
            shadow_len.push_back(len);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // Command driver: a transfer completes at an edge with start high and busy low.
    always @(posedge clk)
    begin : drive
        route_cmd_t nxt;
        bit quiet;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            quiet = (sent_count >= 150 && sent_count < 300);
            if (start && !busy)
            begin
                pending_rsp.push_back(predict_response(cur_cmd));
                sent_count <= sent_count + 1;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (cmd_fifo.size() == 0)
                begin
                    start <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 99) < 7)
                begin
                    gap_left <= $urandom_range(0, 12);
                    start <= 1'b0;
                end
                else
                begin
                    nxt = cmd_fifo.pop_front();
                    cur_cmd <= nxt;
                    start <= 1'b1;
                    action <= nxt.action;
                    address <= nxt.address;
                    prefix_len <= nxt.plen;
                    as_number <= nxt.asn;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        route_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: result with no transfer pending, expected none, actual %0b/%0d/%0d/%0d",
                         $time, hit, found_as, found_len, status);
                err_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("hit", 32'(want.hit), 32'(hit));
                check_field("found_as", 32'(want.found_as), 32'(found_as));
                check_field("found_len", 32'(want.found_len), 32'(found_len));
                check_field("status", 32'(want.status), 32'(status));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        int i;
        int k;
        int roll;
        logic [5:0]  len;
        logic [31:0] net;
        logic [31:0] msk;

        add_cmd(ACT_LOOKUP, 32'h0A00_0001, 6'd0, 16'h0);
        add_cmd(ACT_UNUSED, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
        add_cmd(ACT_INSERT, 32'h0, 6'd8, 16'h1234);
        add_cmd(ACT_INSERT, 32'h0A00_0000, 6'd0, 16'h1);
        add_cmd(ACT_INSERT, 32'h0A00_0000, 6'd33, 16'h2);
        add_cmd(ACT_INSERT, 32'hFFFF_FFFF, 6'd63, 16'h3);
        add_cmd(ACT_INSERT, 32'hFFFF_FFFF, 6'd32, 16'hFFFF);
        add_cmd(ACT_INSERT, 32'h8000_0000, 6'd1, 16'd1);
        add_cmd(ACT_INSERT, 32'h0A00_0000, 6'd8, 16'd100);
        add_cmd(ACT_INSERT, 32'h0A00_0000, 6'd8, 16'd101);
        add_cmd(ACT_INSERT, 32'h0A01_0000, 6'd16, 16'd200);
        add_cmd(ACT_INSERT, 32'h0A00_0001, 6'd8, 16'd300);
        add_cmd(ACT_INSERT, 32'h0000_0001, 6'd32, 16'h0);
        add_cmd(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0, 16'h0);
        add_cmd(ACT_LOOKUP, 32'h8000_0000, 6'd0, 16'h0);
        add_cmd(ACT_LOOKUP, 32'h8FFF_FFFF, 6'd0, 16'h0);
        add_cmd(ACT_LOOKUP, 32'h0A00_00FF, 6'd0, 16'h0);
        add_cmd(ACT_LOOKUP, 32'h0A01_FFFF, 6'd0, 16'h0);
        add_cmd(ACT_LOOKUP, 32'h0000_0001, 6'd0, 16'h0);
        add_cmd(ACT_LOOKUP, 32'h0000_0000, 6'd0, 16'h0);
        add_cmd(ACT_LOOKUP, 32'h7FFF_FFFF, 6'd63, 16'hFFFF);
        add_cmd(ACT_UNUSED, 32'h0, 6'd0, 16'h0);
        add_cmd(ACT_CLEAR, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
        add_cmd(ACT_LOOKUP, 32'h0A00_0001, 6'd0, 16'h0);

        for (i = 0; i < RAND_ITEMS; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3 || shadow_net.size() >= SHADOW_MAX)
            begin
                add_cmd(ACT_CLEAR, $urandom, 6'($urandom), 16'($urandom));
            end
            else if (roll < 5)
            begin
                add_cmd(ACT_UNUSED, $urandom, 6'($urandom), 16'($urandom));
            end
            else if (roll < 11)
            begin
                case ($urandom_range(0, 2))
                    0: add_cmd(ACT_INSERT, 32'h0, 6'($urandom), 16'($urandom));
                    1: add_cmd(ACT_INSERT, $urandom, 6'd0, 16'($urandom));
                    default: add_cmd(ACT_INSERT, $urandom, 6'($urandom_range(33, 63)),
                                     16'($urandom));
                endcase
            end
            else if (roll < 48)
            begin
                k = $urandom_range(0, 99);
                if (shadow_net.size() != 0 && k < 10)
                begin
                    k = $urandom_range(0, shadow_net.size() - 1);
                    net = shadow_net[k];
                    len = shadow_len[k];
                end
                else if (shadow_net.size() != 0 && k < 35)
                begin
                    k = $urandom_range(0, shadow_net.size() - 1);
                    len = shadow_len[k] + 6'($urandom_range(0, 8));
                    if (len > LEN_MAX)
                    begin
                        len = LEN_MAX;
                    end
                    net = (shadow_net[k] | ($urandom & ~prefix_mask(shadow_len[k])))
                          & prefix_mask(len);
                end
                else if (k < 45)
                begin
                    len = 6'($urandom_range(1, 31));
                    net = $urandom | 32'h1;
                end
                else
                begin
                    len = 6'($urandom_range(1, 32));
                    net = $urandom & prefix_mask(len);
                end
                if (net == 32'h0)
                begin
                    net = prefix_mask(len);
                end
                add_cmd(ACT_INSERT, net, len, 16'($urandom));
            end
            else
            begin
                k = $urandom_range(0, 99);
                if (shadow_net.size() != 0 && k < 60)
                begin
                    k = $urandom_range(0, shadow_net.size() - 1);
                    msk = prefix_mask(shadow_len[k]);
                    net = shadow_net[k] | ($urandom & ~msk);
                end
                else if (shadow_net.size() != 0 && k < 70)
                begin
                    net = shadow_net[$urandom_range(0, shadow_net.size() - 1)];
                end
                else
                begin
                    net = $urandom;
                end
                add_cmd(ACT_LOOKUP, net, 6'($urandom), 16'($urandom));
            end
        end

        add_cmd(ACT_CLEAR, 32'h0, 6'd0, 16'h0);
        for (i = 0; i < FILL_ITEMS; i++)
        begin
            add_cmd(ACT_INSERT, 32'(i + 1) << 8, 6'd24, 16'($urandom));
        end
        add_cmd(ACT_INSERT, 32'h0, 6'd24, 16'h5555);
        add_cmd(ACT_INSERT, 32'hC0A8_0000, 6'd16, 16'hAAAA);
        add_cmd(ACT_INSERT, 32'h0000_0100, 6'd40, 16'h1);
        for (i = 0; i < 12; i++)
        begin
            if (i % 3 == 2)
            begin
                net = $urandom;
            end
            else
            begin
                net = (32'($urandom_range(1, FILL_ITEMS)) << 8) | 32'($urandom_range(0, 255));
            end
            add_cmd(ACT_LOOKUP, net, 6'd0, 16'h0);
        end
        add_cmd(ACT_LOOKUP, 32'h0000_0100, 6'd0, 16'h0);
        add_cmd(ACT_LOOKUP, 32'(FILL_ITEMS) << 8, 6'd0, 16'h0);
        add_cmd(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0, 16'h0);
        add_cmd(ACT_CLEAR, 32'h0, 6'd0, 16'h0);
        add_cmd(ACT_INSERT, 32'hC0A8_0000, 6'd16, 16'hAAAA);
        add_cmd(ACT_LOOKUP, 32'hC0A8_1234, 6'd0, 16'h0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_count != issued_count || pending_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
